>>> sv/pcrc_pkg.sv
// package: constants, types and helper functions of the crc engine
`timescale 1ns / 1ps
`default_nettype none

package pcrc_pkg;

    localparam int MAX_CRC_WIDTH = 32;
    localparam int TABLE_DEPTH   = 256;
    localparam int TBL_AW        = $clog2(TABLE_DEPTH);
    localparam int CRC_W         = 32;
    localparam int DATA_W        = 8;
    localparam int CW_W          = 6;
    localparam int SH_W          = 5;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;
    localparam int REG_IDX_W     = 3;

    localparam logic [CW_W-1:0] MIN_WIDTH = CW_W'(8);
    localparam logic [CW_W-1:0] MAX_WIDTH = CW_W'(MAX_CRC_WIDTH);

    localparam logic [REG_IDX_W-1:0] REG_CRC_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POLY        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INIT_VALUE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INIT_DIRECT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_XOR_OUT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REFLECT_IN  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REFLECT_OUT = 3'd6;

    typedef struct packed {
        logic [SH_W-1:0]  w_m8;
        logic [SH_W-1:0]  sh;
        logic [CRC_W-1:0] mask;
        logic             refl_in;
        logic             refl_out;
        logic [CRC_W-1:0] xor_out;
        logic [CRC_W-1:0] start_work;
        logic             building;
    } t_cfg_view;

    function automatic logic [CRC_W-1:0] f_rev32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++) begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] f_rev8(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int k = 0; k < DATA_W; k++) begin
            r[k] = v[DATA_W-1-k];
        end
        return r;
    endfunction

    // one shift step of the generator on a left-aligned value
    function automatic logic [CRC_W-1:0] f_step(input logic [CRC_W-1:0] v,
                                                input logic [CRC_W-1:0] g_la);
        logic [CRC_W-1:0] r;
        r = {v[CRC_W-2:0], 1'b0};
        if (v[CRC_W-1]) begin
            r = r ^ g_la;
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] f_table_entry(input logic [TBL_AW-1:0] idx,
                                                       input logic [SH_W-1:0]   sh,
                                                       input logic [CRC_W-1:0]  g_la,
                                                       input logic              refl);
        logic [DATA_W-1:0] b;
        logic [CRC_W-1:0]  v;
        b = refl ? f_rev8(DATA_W'(idx)) : DATA_W'(idx);
        v = {b, {(CRC_W-DATA_W){1'b0}}};
        for (int k = 0; k < DATA_W; k++) begin
            v = f_step(v, g_la);
        end
        return refl ? f_rev32(v) : (v >> sh);
    endfunction

endpackage

`default_nettype wire

>>> sv/pcrc_ifs.sv
// interfaces: input byte channel and result channel
`timescale 1ns / 1ps
`default_nettype none

interface pcrc_in_if;
    logic                       valid;
    logic                       ready;
    logic [pcrc_pkg::DATA_W-1:0] data_byte;
    logic                       first_byte;
    logic                       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface pcrc_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcrc_pkg::CRC_W-1:0]  crc_value;

    modport source (output valid, crc_value, input ready);
    modport sink   (input valid, crc_value, output ready);
endinterface

`default_nettype wire

>>> sv/parameterized_crc_engine_unit.sv
// top level: parameterized crc engine with apb configuration
`timescale 1ns / 1ps
`default_nettype none

// usage
// i_item carries one message byte per item with first_byte and last_byte marks;
// first_byte reloads the register from the start value before that byte.
// o_result carries one crc_value per item marked last_byte, masked to the width.
// the apb port writes crc_width, poly, init_value, init_is_direct, xor_out,
// reflect_in and reflect_out at byte addresses 0, 4, ... 24; pready is always high.
// o_result.valid rises when the last byte, registered into the table read stage,
// moves on into the result register, unless a stalled result holds it back.
// throughput: one byte per cycle while i_item.ready is high; the table read of
// the next byte takes its address from the register update forwarded out of
// the table read stage. after reset and after every register write the
// 256-entry table is rebuilt, one entry a cycle, while i_item.ready is low.
// a stalled result stays in the output register; further bytes are still taken
// until a second finished crc would have to wait behind it.

module parameterized_crc_engine_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    pcrc_in_if.sink                           i_item,
    pcrc_out_if.source                        o_result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pcrc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pcrc_pkg::APB_DW-1:0]  pwdata,
    output logic      [pcrc_pkg::APB_DW-1:0]  prdata,
    output logic                              pready
);

    pcrc_pkg::t_cfg_view             cfg_view;
    logic                            tbl_we;
    logic [pcrc_pkg::TBL_AW-1:0]     tbl_waddr;
    logic [pcrc_pkg::CRC_W-1:0]      tbl_wdata;
    logic                            tbl_re;
    logic [pcrc_pkg::TBL_AW-1:0]     tbl_raddr;
    logic [pcrc_pkg::CRC_W-1:0]      tbl_rdata;

    pcrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_cfg       (cfg_view)
    );

    pcrc_ram #(
        .WIDTH (pcrc_pkg::CRC_W),
        .DEPTH (pcrc_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    pcrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_result    (o_result),
        .i_cfg       (cfg_view),
        .i_tbl_rdata (tbl_rdata),
        .o_tbl_re    (tbl_re),
        .o_tbl_raddr (tbl_raddr)
    );

    // no table lookup while the table is being rebuilt
    a_no_read_during_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> !tbl_re)
        else $error("table read during rebuild");

    // a last byte always yields a waiting result via the stage 1 and output registers
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.last_byte) |=> ##1 o_result.valid)
        else $error("no result after last byte");

    // a fresh result only follows a last byte that passed the stage 1 register
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |->
            $past(i_item.valid && i_item.ready && i_item.last_byte, 2))
        else $error("result without last byte");

endmodule

`default_nettype wire

>>> sv/pcrc_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pcrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/pcrc_cfg.sv
// configuration registers, table build sweep and start value
`timescale 1ns / 1ps
`default_nettype none

module pcrc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pcrc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [pcrc_pkg::APB_DW-1:0]     pwdata,
    output logic      [pcrc_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready,
    output logic                                 o_tbl_we,
    output logic      [pcrc_pkg::TBL_AW-1:0]     o_tbl_waddr,
    output logic      [pcrc_pkg::CRC_W-1:0]      o_tbl_wdata,
    output pcrc_pkg::t_cfg_view                  o_cfg
);

    logic [pcrc_pkg::CW_W-1:0]      r_crc_width;
    logic [pcrc_pkg::CRC_W-1:0]     r_poly;
    logic [pcrc_pkg::CRC_W-1:0]     r_init;
    logic                           r_init_direct;
    logic [pcrc_pkg::CRC_W-1:0]     r_xor_out;
    logic                           r_refl_in;
    logic                           r_refl_out;
    logic                           r_build;
    logic [pcrc_pkg::TBL_AW-1:0]    r_bcnt;
    logic [pcrc_pkg::CRC_W-1:0]     r_ds_la;

    logic [pcrc_pkg::REG_IDX_W-1:0] idx;
    logic                           wr;
    logic                           wr_hit;
    logic [pcrc_pkg::CW_W-1:0]      w;
    logic [pcrc_pkg::CW_W-1:0]      sh_full;
    logic [pcrc_pkg::SH_W-1:0]      sh;
    logic [pcrc_pkg::CRC_W-1:0]     g_la;

    assign pready = 1'b1;
    assign idx    = paddr[pcrc_pkg::APB_AW-1:2];
    assign wr     = psel && penable && pwrite;

    always_comb begin
        if (r_crc_width < pcrc_pkg::MIN_WIDTH) begin
            w = pcrc_pkg::MIN_WIDTH;
        end else if (r_crc_width > pcrc_pkg::MAX_WIDTH) begin
            w = pcrc_pkg::MAX_WIDTH;
        end else begin
            w = r_crc_width;
        end
    end

    assign sh_full = pcrc_pkg::CW_W'(pcrc_pkg::CRC_W) - w;
    assign sh      = sh_full[pcrc_pkg::SH_W-1:0];
    assign g_la    = r_poly << sh;

    always_comb begin
        wr_hit = 1'b0;
        if (wr) begin
            unique case (idx)
                pcrc_pkg::REG_CRC_WIDTH, pcrc_pkg::REG_POLY, pcrc_pkg::REG_INIT_VALUE,
                pcrc_pkg::REG_INIT_DIRECT, pcrc_pkg::REG_XOR_OUT,
                pcrc_pkg::REG_REFLECT_IN, pcrc_pkg::REG_REFLECT_OUT: wr_hit = 1'b1;
                default: wr_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_width   <= pcrc_pkg::CW_W'(16);
            r_poly        <= 32'h0000_8005;
            r_init        <= '0;
            r_init_direct <= 1'b1;
            r_xor_out     <= '0;
            r_refl_in     <= 1'b0;
            r_refl_out    <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                pcrc_pkg::REG_CRC_WIDTH:   r_crc_width   <= pwdata[pcrc_pkg::CW_W-1:0];
                pcrc_pkg::REG_POLY:        r_poly        <= pwdata;
                pcrc_pkg::REG_INIT_VALUE:  r_init        <= pwdata;
                pcrc_pkg::REG_INIT_DIRECT: r_init_direct <= pwdata[0];
                pcrc_pkg::REG_XOR_OUT:     r_xor_out     <= pwdata;
                pcrc_pkg::REG_REFLECT_IN:  r_refl_in     <= pwdata[0];
                pcrc_pkg::REG_REFLECT_OUT: r_refl_out    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // table sweep, one entry a cycle; start value settles while the sweep runs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build <= 1'b1;
            r_bcnt  <= '0;
        end else if (wr_hit) begin
            r_build <= 1'b1;
            r_bcnt  <= '0;
        end else if (r_build) begin
            r_bcnt <= r_bcnt + 1'b1;
            if (r_bcnt == pcrc_pkg::TBL_AW'(pcrc_pkg::TABLE_DEPTH - 1)) begin
                r_build <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_build) begin
            if (r_bcnt == '0) begin
                r_ds_la <= r_init << sh;
            end else if (!r_init_direct && (r_bcnt <= pcrc_pkg::TBL_AW'(w))) begin
                r_ds_la <= pcrc_pkg::f_step(r_ds_la, g_la);
            end
        end
    end

    assign o_tbl_we    = r_build;
    assign o_tbl_waddr = r_bcnt;
    assign o_tbl_wdata = pcrc_pkg::f_table_entry(r_bcnt, sh, g_la, r_refl_in);

    always_comb begin
        o_cfg.w_m8       = pcrc_pkg::SH_W'(w - pcrc_pkg::MIN_WIDTH);
        o_cfg.sh         = sh;
        o_cfg.mask       = {pcrc_pkg::CRC_W{1'b1}} >> sh;
        o_cfg.refl_in    = r_refl_in;
        o_cfg.refl_out   = r_refl_out;
        o_cfg.xor_out    = r_xor_out;
        o_cfg.start_work = r_refl_in ? pcrc_pkg::f_rev32(r_ds_la) : (r_ds_la >> sh);
        o_cfg.building   = r_build;
    end

    always_comb begin
        unique case (idx)
            pcrc_pkg::REG_CRC_WIDTH:   prdata = pcrc_pkg::APB_DW'(r_crc_width);
            pcrc_pkg::REG_POLY:        prdata = r_poly;
            pcrc_pkg::REG_INIT_VALUE:  prdata = r_init;
            pcrc_pkg::REG_INIT_DIRECT: prdata = pcrc_pkg::APB_DW'(r_init_direct);
            pcrc_pkg::REG_XOR_OUT:     prdata = r_xor_out;
            pcrc_pkg::REG_REFLECT_IN:  prdata = pcrc_pkg::APB_DW'(r_refl_in);
            pcrc_pkg::REG_REFLECT_OUT: prdata = pcrc_pkg::APB_DW'(r_refl_out);
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/pcrc_core.sv
// byte pipeline: table address, table read, register update, result register
`timescale 1ns / 1ps
`default_nettype none

module pcrc_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    pcrc_in_if.sink                          i_item,
    pcrc_out_if.source                       o_result,
    input  wire pcrc_pkg::t_cfg_view         i_cfg,
    input  wire logic [pcrc_pkg::CRC_W-1:0]  i_tbl_rdata,
    output logic                             o_tbl_re,
    output logic      [pcrc_pkg::TBL_AW-1:0] o_tbl_raddr
);

    logic                        r_s1_valid;
    logic                        r_s1_last;
    logic [pcrc_pkg::CRC_W-1:0]  r_s1_v;
    logic [pcrc_pkg::CRC_W-1:0]  r_crc;
    logic                        r_out_valid;
    logic [pcrc_pkg::CRC_W-1:0]  r_out;

    logic                        s1_stall;
    logic                        s1_done;
    logic                        acc;
    logic [pcrc_pkg::CRC_W-1:0]  n_crc;
    logic [pcrc_pkg::CRC_W-1:0]  n_out;
    logic [pcrc_pkg::CRC_W-1:0]  shifted;
    logic [pcrc_pkg::CRC_W-1:0]  live;
    logic [pcrc_pkg::CRC_W-1:0]  base;
    logic [pcrc_pkg::CRC_W-1:0]  top_bits;
    logic [pcrc_pkg::CRC_W-1:0]  mirrored;

    assign s1_stall = r_s1_valid && r_s1_last && r_out_valid && !o_result.ready;
    assign s1_done  = r_s1_valid && !s1_stall;
    assign i_item.ready = !i_cfg.building && !s1_stall;
    assign acc = i_item.valid && i_item.ready;

    // stage 1: fold the table word into the register
    assign shifted = i_cfg.refl_in ? (r_s1_v >> pcrc_pkg::DATA_W) : (r_s1_v << pcrc_pkg::DATA_W);
    assign n_crc   = (shifted ^ i_tbl_rdata) & i_cfg.mask;
    assign mirrored = pcrc_pkg::f_rev32(n_crc) >> i_cfg.sh;
    assign n_out   = (((i_cfg.refl_in ^ i_cfg.refl_out) ? mirrored : n_crc) ^ i_cfg.xor_out)
                     & i_cfg.mask;

    // stage 0: forward the update in flight into the next address
    assign live     = r_s1_valid ? n_crc : r_crc;
    assign base     = (i_item.first_byte ? i_cfg.start_work : live) & i_cfg.mask;
    assign top_bits = base >> i_cfg.w_m8;

    assign o_tbl_re    = acc;
    assign o_tbl_raddr = i_cfg.refl_in ? (base[pcrc_pkg::TBL_AW-1:0] ^ i_item.data_byte)
                                       : (top_bits[pcrc_pkg::TBL_AW-1:0] ^ i_item.data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc || s1_stall;
            if (s1_done) begin
                r_crc <= n_crc;
            end
            if (s1_done && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_v    <= base;
            r_s1_last <= i_item.last_byte;
        end
        if (s1_done && r_s1_last) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.crc_value = r_out;

endmodule

`default_nettype wire
